FILE: hw/rtl/etsq_pkg.sv
// etsq_pkg: types, codes and field widths shared by the event time sorted queue
// depends on nothing; imported by the interfaces and every module of the block

package etsq_pkg;

	localparam int ID_W     = 6;
	localparam int TIME_W   = 48;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;
	localparam int ACTIVE_W = 7;

	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd64;

	localparam logic CMD_INSERT  = 1'b0;
	localparam logic CMD_REINDEX = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_WORK
	} state_t;

	typedef struct packed {
		logic load;
		logic drop;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic drop_needed;
		logic out_free;
	} dp_sts_t;

endpackage

FILE: hw/rtl/etsq_ifs.sv
// etsq_req_if and etsq_rsp_if: valid/ready channels of the event time sorted queue
// depends on etsq_pkg for the field widths

interface etsq_req_if;
	import etsq_pkg::*;

	logic              valid;
	logic              ready;
	logic              command;
	logic [ID_W-1:0]   particle_id;
	logic [TIME_W-1:0] event_time;

	modport source(output valid, command, particle_id, event_time, input ready);
	modport sink(input valid, command, particle_id, event_time, output ready);
endinterface

interface etsq_rsp_if;
	import etsq_pkg::*;

	logic                valid;
	logic                ready;
	logic [ID_W-1:0]     head_id;
	logic [TIME_W-1:0]   head_time;
	logic [COUNT_W-1:0]  entry_count;
	logic [STATUS_W-1:0] status;

	modport source(output valid, head_id, head_time, entry_count, status, input ready);
	modport sink(input valid, head_id, head_time, entry_count, status, output ready);
endinterface

FILE: hw/rtl/etsq_ctrl.sv
// etsq_ctrl: controller state machine of the event time sorted queue
// depends on etsq_pkg; drives commands into etsq_datapath and reads its status

module etsq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output etsq_pkg::ctrl_cmd_t cmd,
	input  etsq_pkg::dp_sts_t   sts
);
	import etsq_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		in_ready   = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_WORK;
				end
			end
			ST_WORK: begin
				if (sts.drop_needed) begin
					cmd.drop = 1'b1;
				end else if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/etsq_datapath.sv
// etsq_datapath: sorted shift-register cell chain, item registers and output register
// depends on etsq_pkg; sequenced by etsq_ctrl through ctrl_cmd_t and dp_sts_t

module etsq_datapath #(
	parameter int DEPTH     = 64,
	parameter int TIME_BITS = 48
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  etsq_pkg::ctrl_cmd_t               cmd,
	output etsq_pkg::dp_sts_t                 sts,
	input  logic                              cfg_we,
	input  logic [etsq_pkg::ACTIVE_W-1:0]     cfg_wdata,
	input  logic                              in_command,
	input  logic [etsq_pkg::ID_W-1:0]         in_id,
	input  logic [etsq_pkg::TIME_W-1:0]       in_time,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [etsq_pkg::ID_W-1:0]         out_head_id,
	output logic [etsq_pkg::TIME_W-1:0]       out_head_time,
	output logic [etsq_pkg::COUNT_W-1:0]      out_count,
	output logic [etsq_pkg::STATUS_W-1:0]     out_status
);
	import etsq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int TW = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;

	logic [ID_W-1:0]     slot_id_q   [DEPTH];
	logic [TW-1:0]       slot_time_q [DEPTH];
	logic [ID_W-1:0]     up_id       [DEPTH];
	logic [TW-1:0]       up_time     [DEPTH];
	logic [ID_W-1:0]     dn_id       [DEPTH];
	logic [TW-1:0]       dn_time     [DEPTH];
	logic [DEPTH-1:0]    valid;
	logic [DEPTH-1:0]    mt;
	logic [DEPTH-1:0]    lt;
	logic [DEPTH-1:0]    pre;
	logic [DEPTH-1:0]    take_new;

	logic [CW-1:0]       count_q;
	logic [ACTIVE_W-1:0] active_q;
	logic                cmd_q;
	logic [ID_W-1:0]     id_q;
	logic [TW-1:0]       time_q;
	logic                found_q;

	logic                out_valid_q;
	logic [ID_W-1:0]     head_id_q;
	logic [TIME_W-1:0]   head_time_q;
	logic [COUNT_W-1:0]  count_out_q;
	logic [STATUS_W-1:0] status_q;

	logic                full;
	logic                ins_ok;
	logic [CW-1:0]       count_nxt;
	logic [ID_W-1:0]     head_id_nxt;
	logic [TW-1:0]       head_time_nxt;
	logic [STATUS_W-1:0] status_nxt;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign valid[i] = count_q > CW'(i);
		assign mt[i]    = valid[i] && (slot_id_q[i] == id_q);
		assign lt[i]    = valid[i] && (slot_time_q[i] < time_q);
		assign pre[i]   = |mt[i:0];

		if (i < DEPTH - 1) begin : g_up
			assign up_id[i]   = slot_id_q[i+1];
			assign up_time[i] = slot_time_q[i+1];
		end else begin : g_up_last
			assign up_id[i]   = slot_id_q[i];
			assign up_time[i] = slot_time_q[i];
		end

		if (i == 0) begin : g_dn_first
			assign dn_id[i]    = id_q;
			assign dn_time[i]  = time_q;
			assign take_new[i] = !lt[i];
		end else begin : g_dn
			assign dn_id[i]    = slot_id_q[i-1];
			assign dn_time[i]  = slot_time_q[i-1];
			assign take_new[i] = !lt[i] && lt[i-1];
		end

		always_ff @(posedge clk) begin
			if (cmd.drop && pre[i]) begin
				slot_id_q[i]   <= up_id[i];
				slot_time_q[i] <= up_time[i];
			end else if (cmd.finish && ins_ok && !lt[i]) begin
				if (take_new[i]) begin
					slot_id_q[i]   <= id_q;
					slot_time_q[i] <= time_q;
				end else begin
					slot_id_q[i]   <= dn_id[i];
					slot_time_q[i] <= dn_time[i];
				end
			end
		end
	end

	assign full   = (32'(count_q) >= 32'(active_q)) || (32'(count_q) >= 32'(DEPTH));
	assign ins_ok = !full;

	always_comb begin
		count_nxt     = count_q;
		head_id_nxt   = '0;
		head_time_nxt = '0;
		if (ins_ok) begin
			count_nxt = CW'(count_q + 1'b1);
		end
		if (ins_ok && !lt[0]) begin
			head_id_nxt   = id_q;
			head_time_nxt = time_q;
		end else if (valid[0]) begin
			head_id_nxt   = slot_id_q[0];
			head_time_nxt = slot_time_q[0];
		end
		if (full) begin
			status_nxt = STATUS_FULL;
		end else if (cmd_q == CMD_REINDEX && !found_q) begin
			status_nxt = STATUS_ABSENT;
		end else begin
			status_nxt = STATUS_OK;
		end
	end

	assign sts.drop_needed = (cmd_q == CMD_REINDEX) && (|mt);
	assign sts.out_free    = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			active_q    <= ACTIVE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				active_q <= cfg_wdata;
			end
			if (cmd.drop) begin
				count_q <= CW'(count_q - 1'b1);
			end else if (cmd.finish) begin
				count_q <= count_nxt;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q   <= in_command;
			id_q    <= in_id;
			time_q  <= TW'(in_time);
			found_q <= 1'b0;
		end else if (cmd.drop) begin
			found_q <= 1'b1;
		end
		if (cmd.finish) begin
			head_id_q   <= head_id_nxt;
			head_time_q <= TIME_W'(head_time_nxt);
			count_out_q <= COUNT_W'(count_nxt);
			status_q    <= status_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_head_id   = head_id_q;
	assign out_head_time = head_time_q;
	assign out_count     = count_out_q;
	assign out_status    = status_q;

	a_drop_dec : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drop |=> count_q == CW'($past(count_q) - 1'b1))
		else $error("count not decremented by removal");

	a_ins_inc : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && ins_ok |=> count_q == CW'($past(count_q) + 1'b1))
		else $error("count not incremented by insertion");

	a_finish_out : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("finished item left no result");

	a_sorted_head : assert property (@(posedge clk) disable iff (!arst_n)
		valid[1] |-> slot_time_q[0] <= slot_time_q[1])
		else $error("head entries out of order");

	a_bounded : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && full |=> count_q == $past(count_q))
		else $error("full queue changed count");

endmodule

FILE: hw/rtl/event_time_sorted_queue.sv
// event_time_sorted_queue: one result beat per command beat; an insert is accepted in the idle state and
// its result registered from the work state, a reindex first does one cell-chain shift per
// held copy of its id (one removal each); the next command beat is taken back in the idle
// state after a result is registered; a pending result beat holds the sequencer
// reset: queue empty, active entries 64, slot contents not cleared
// depends on etsq_pkg, etsq_ifs, etsq_ctrl, etsq_datapath

module event_time_sorted_queue #(
	parameter int DEPTH     = 64,
	parameter int TIME_BITS = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [etsq_pkg::ACTIVE_W-1:0] cfg_wdata,
	etsq_req_if.sink                      req,
	etsq_rsp_if.source                    rsp
);
	import etsq_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	etsq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	etsq_datapath #(
		.DEPTH     (DEPTH),
		.TIME_BITS (TIME_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_command    (req.command),
		.in_id         (req.particle_id),
		.in_time       (req.event_time),
		.out_valid     (rsp.valid),
		.out_ready     (rsp.ready),
		.out_head_id   (rsp.head_id),
		.out_head_time (rsp.head_time),
		.out_count     (rsp.entry_count),
		.out_status    (rsp.status)
	);

endmodule

FILE: test/tb_event_time_sorted_queue.sv
// tb_event_time_sorted_queue: self-checking bench for the event time sorted queue
// predicts head id, head time, count and status per command beat and checks every result beat
// depends on etsq_pkg, etsq_ifs and event_time_sorted_queue

module tb_event_time_sorted_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import etsq_pkg::*;

	localparam int QDEPTH      = 64;
	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 100;

	typedef struct packed {
		logic [ID_W-1:0]     head_id;
		logic [TIME_W-1:0]   head_time;
		logic [COUNT_W-1:0]  entry_count;
		logic [STATUS_W-1:0] status;
	} head_report_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [ACTIVE_W-1:0] cfg_wdata;

	etsq_req_if req_ch();
	etsq_rsp_if rsp_ch();

	event_time_sorted_queue uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	logic [ID_W-1:0]     slot_id_q[QDEPTH];
	logic [TIME_W-1:0]   slot_time_q[QDEPTH];
	int                  held;
	logic [ACTIVE_W-1:0] active_cap;

	head_report_t pending_reports[$];
	int           faults;
	int           beats_sent;
	int           beats_checked;
	int           cycles;
	int           status_seen[4];
	bit           quiet;
	int           hold_request;
	int           hold_left;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_event_time_sorted_queue failed");
			$finish;
		end
	end

	function automatic int capacity_limit();
		return (int'(active_cap) > QDEPTH) ? QDEPTH : int'(active_cap);
	endfunction

	function automatic bit drop_copies(logic [ID_W-1:0] id);
		int wr;
		bit found;
		wr = 0;
		found = 1'b0;
		for (int rd = 0; rd < held; rd++) begin
			if (slot_id_q[rd] == id) begin
				found = 1'b1;
			end else begin
				slot_id_q[wr] = slot_id_q[rd];
				slot_time_q[wr] = slot_time_q[rd];
				wr++;
			end
		end
		held = wr;
		return found;
	endfunction

	function automatic bit place_event(logic [ID_W-1:0] id, logic [TIME_W-1:0] t);
		int pos;
		if (held >= capacity_limit() || held >= QDEPTH)
			return 1'b0;
		pos = 0;
		while (pos < held && slot_time_q[pos] < t)
			pos++;
		for (int k = held; k > pos; k--) begin
			slot_id_q[k] = slot_id_q[k-1];
			slot_time_q[k] = slot_time_q[k-1];
		end
		slot_id_q[pos] = id;
		slot_time_q[pos] = t;
		held++;
		return 1'b1;
	endfunction

	function automatic head_report_t apply_command(logic cmd, logic [ID_W-1:0] id,
			logic [TIME_W-1:0] t);
		head_report_t r;
		bit present;
		r.status = STATUS_OK;
		if (cmd == CMD_INSERT) begin
			if (!place_event(id, t))
				r.status = STATUS_FULL;
		end else begin
			present = drop_copies(id);
			if (!place_event(id, t))
				r.status = STATUS_FULL;
			else if (!present)
				r.status = STATUS_ABSENT;
		end
		r.head_id = (held > 0) ? slot_id_q[0] : '0;
		r.head_time = (held > 0) ? slot_time_q[0] : '0;
		r.entry_count = COUNT_W'(held);
		return r;
	endfunction

	function automatic logic [TIME_W-1:0] pick_time();
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3, 4: return TIME_W'($urandom_range(7)) << 16;
			default: return w[TIME_W-1:0];
		endcase
	endfunction

	// receiver side: random stalls, or a counted hold when requested
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= quiet || ($urandom_range(99) >= 15);
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin : check_beat
			head_report_t got;
			head_report_t want;
			got.head_id = rsp_ch.head_id;
			got.head_time = rsp_ch.head_time;
			got.entry_count = rsp_ch.entry_count;
			got.status = rsp_ch.status;
			beats_checked++;
			if (pending_reports.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected result beat: id %0d time %h count %0d status %0d",
						got.head_id, got.head_time, got.entry_count, got.status);
			end else begin
				want = pending_reports[0];
				pending_reports.delete(0);
				if (got.status < 3)
					status_seen[got.status]++;
				if (got !== want) begin
					faults++;
					if (faults <= 10)
						$display("mismatch at beat %0d: exp id %0d time %h count %0d status %0d,",
							beats_checked, want.head_id, want.head_time,
							want.entry_count, want.status,
							" got id %0d time %h count %0d status %0d",
							got.head_id, got.head_time, got.entry_count, got.status);
				end
			end
		end
	end

	task automatic send_command(input logic cmd, input logic [ID_W-1:0] id,
			input logic [TIME_W-1:0] t);
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 15) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.particle_id <= id;
		req_ch.event_time <= t;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		pending_reports = {pending_reports, apply_command(cmd, id, t)};
		beats_sent++;
	endtask

	task automatic drain_reports();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [ACTIVE_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		active_cap = value;
	endtask

	task automatic random_command();
		logic cmd;
		logic [ID_W-1:0] id;
		logic [TIME_W-1:0] t;
		t = pick_time();
		if (held > 0 && held >= capacity_limit() && $urandom_range(99) < 75) begin
			cmd = CMD_REINDEX;
			id = slot_id_q[$urandom_range(held-1)];
		end else begin
			cmd = ($urandom_range(99) < 55) ? CMD_INSERT : CMD_REINDEX;
			if (cmd == CMD_REINDEX && held > 0 && $urandom_range(99) < 70)
				id = slot_id_q[$urandom_range(held-1)];
			else
				id = ID_W'($urandom_range(63));
		end
		send_command(cmd, id, t);
	endtask

	task automatic test_directed();
		send_command(CMD_INSERT, 6'd0, '1);
		send_command(CMD_INSERT, 6'd63, '0);
		send_command(CMD_INSERT, 6'd5, 48'h1_0000);
		// equal time goes ahead of the older entry
		send_command(CMD_INSERT, 6'd6, 48'h1_0000);
		// duplicate, then a reindex removes both copies
		send_command(CMD_INSERT, 6'd5, 48'h2_0000);
		send_command(CMD_REINDEX, 6'd5, 48'h8000);
		send_command(CMD_REINDEX, 6'd9, 48'h3_0000);
		send_command(CMD_REINDEX, 6'd63, '1);
		drain_reports();
		write_capacity(7'd5);
		send_command(CMD_INSERT, 6'd10, 48'h5);
		send_command(CMD_REINDEX, 6'd11, 48'h5);
		send_command(CMD_REINDEX, 6'd6, '0);
		drain_reports();
		// capacity below the held count
		write_capacity(7'd2);
		send_command(CMD_INSERT, 6'd12, 48'h7);
		send_command(CMD_REINDEX, 6'd0, 48'h7);
		drain_reports();
		// zero capacity empties the queue through reindexes
		write_capacity(7'd0);
		send_command(CMD_REINDEX, 6'd6, 48'h1);
		send_command(CMD_REINDEX, 6'd5, 48'h2);
		send_command(CMD_REINDEX, 6'd9, 48'h3);
		send_command(CMD_REINDEX, 6'd63, 48'h4);
		send_command(CMD_REINDEX, 6'd0, 48'h5);
		send_command(CMD_INSERT, 6'd1, '1);
		send_command(CMD_REINDEX, 6'd2, '1);
		drain_reports();
		write_capacity(7'd127);
		send_command(CMD_INSERT, 6'd3, '1);
		send_command(CMD_REINDEX, 6'd3, '0);
		drain_reports();
	endtask

	task automatic test_backpressure();
		write_capacity(7'd64);
		hold_request = HOLD_CYCLES;
		repeat (24) random_command();
		drain_reports();
	endtask

	task automatic test_random_phases();
		logic [ACTIVE_W-1:0] caps[9];
		caps = '{7'd64, 7'd127, 7'd8, 7'd1, 7'd0, 7'd2, 7'd33, 7'd0, 7'd64};
		caps[7] = ACTIVE_W'($urandom_range(64, 1));
		foreach (caps[p]) begin
			write_capacity(caps[p]);
			quiet = (p == 6);
			repeat (PHASE_ITEMS) random_command();
			drain_reports();
		end
		quiet = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_INSERT;
		req_ch.particle_id = '0;
		req_ch.event_time = '0;
		rsp_ch.ready = 1'b0;
		held = 0;
		active_cap = ACTIVE_RESET;
		quiet = 1'b0;
		hold_request = 0;
		hold_left = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_backpressure();
		test_random_phases();
		drain_reports();
		faults += pending_reports.size();

		$display("%0d command beats, %0d result beats; ok %0d, full %0d, absent %0d",
			beats_sent, beats_checked, status_seen[0], status_seen[1], status_seen[2]);
		$display("capacity swept 0..127 incl. below held count, with a %0d-cycle output hold",
			HOLD_CYCLES);
		if (faults == 0)
			$display("tb_event_time_sorted_queue passed");
		else
			$display("tb_event_time_sorted_queue failed");
		$finish;
	end

endmodule
